@@ src/smx_pkg.sv @@
// Package with shared types, constants and the exp table for the softmax normalizer.
`timescale 1ns / 1ps
package smx_pkg;

    localparam int MaxLen = 64;
    localparam int AddrW = $clog2(MaxLen);
    localparam int CntW = AddrW + 1;
    localparam int QueueDepth = 2;
    localparam logic [16:0] Log2eQ16 = 17'd94548;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXP_RD,
        ST_EXP_MUL,
        ST_EXP_CALC,
        ST_RECIP,
        ST_EMIT_RD,
        ST_EMIT_MUL,
        ST_EMIT_OUT
    } back_state_t;

    // Vector descriptor handed from the front to the back.
    typedef struct packed {
        logic [CntW-1:0] count;
        logic [15:0]     max_score;
    } vec_desc_t;

    function automatic logic [16:0] exp_tab(input logic [4:0] i);
        logic [16:0] t;
        case (i)
            5'd0: t = 17'd65536;
            5'd1: t = 17'd62757;
            5'd2: t = 17'd60097;
            5'd3: t = 17'd57549;
            5'd4: t = 17'd55109;
            5'd5: t = 17'd52773;
            5'd6: t = 17'd50535;
            5'd7: t = 17'd48393;
            5'd8: t = 17'd46341;
            5'd9: t = 17'd44376;
            5'd10: t = 17'd42495;
            5'd11: t = 17'd40693;
            5'd12: t = 17'd38968;
            5'd13: t = 17'd37316;
            5'd14: t = 17'd35734;
            5'd15: t = 17'd34219;
            default: t = 17'd32768;
        endcase
        return t;
    endfunction

endpackage

@@ src/smx_front.sv @@
// Front end: issues score writes, tracks the maximum and issues vector descriptors.
`timescale 1ns / 1ps
module smx_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      take,
    input  logic [15:0]               score,
    input  logic                      last,
    output logic                      wr_en,
    output logic [smx_pkg::AddrW-1:0] wr_addr,
    output logic [15:0]               wr_data,
    output logic                      desc_valid,
    output smx_pkg::vec_desc_t        desc
);

    logic [smx_pkg::CntW-1:0] count_reg;
    logic [15:0]              max_reg;
    logic [15:0]              max_next;
    logic [smx_pkg::CntW-1:0] count_inc;

    assign count_inc = count_reg + 1'b1;
    assign max_next = (count_reg == '0 || $signed(score) > $signed(max_reg)) ? score : max_reg;
    assign wr_en = take;
    assign wr_addr = count_reg[smx_pkg::AddrW-1:0];
    assign wr_data = score;
    assign desc_valid = take && (last || count_inc == smx_pkg::CntW'(smx_pkg::MaxLen));
    assign desc.count = count_inc;
    assign desc.max_score = max_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            max_reg <= '0;
        end
        else if (take)
        begin
            if (desc_valid)
            begin
                count_reg <= '0;
                max_reg <= '0;
            end
            else
            begin
                count_reg <= count_inc;
                max_reg <= max_next;
            end
        end
    end

endmodule

@@ src/smx_queue.sv @@
// Short descriptor queue between the front and back ends.
`timescale 1ns / 1ps
module smx_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  smx_pkg::vec_desc_t push_data,
    input  logic               pop,
    output logic               not_empty,
    output logic               full,
    output smx_pkg::vec_desc_t head
);

    localparam int PtrW = $clog2(smx_pkg::QueueDepth);

    smx_pkg::vec_desc_t  slot_reg [smx_pkg::QueueDepth];
    logic [PtrW-1:0]     rd_reg;
    logic [PtrW-1:0]     wr_reg;
    logic [PtrW:0]       fill_reg;

    assign not_empty = fill_reg != '0;
    assign full = fill_reg == (PtrW+1)'(smx_pkg::QueueDepth);
    assign head = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0;
            wr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

endmodule

@@ src/smx_recip.sv @@
// Restoring divider that forms round(2^40 / sum), one quotient bit a cycle.
`timescale 1ns / 1ps
module smx_recip (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [22:0] sum,
    output logic        done,
    output logic [24:0] inv
);

    // Dividend 2^40 + sum/2 fits 41 bits; quotient is below 2^25.
    logic [40:0] dvd_reg;
    logic [23:0] rem_reg;
    logic [24:0] quo_reg;
    logic [5:0]  step_reg;
    logic        busy_reg;
    logic [23:0] rem_shift;
    logic        fits;

    assign rem_shift = {rem_reg[22:0], dvd_reg[40]};
    assign fits = rem_shift >= {1'b0, sum};
    assign inv = quo_reg;
    assign done = busy_reg && step_reg == 6'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (go)
        begin
            busy_reg <= 1'b1;
            step_reg <= 6'd41;
        end
        else if (busy_reg)
        begin
            if (step_reg == 6'd0)
                busy_reg <= 1'b0;
            else
                step_reg <= step_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            dvd_reg <= (41'd1 << 40) + 41'(sum >> 1);
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg && step_reg != 6'd0)
        begin
            dvd_reg <= {dvd_reg[39:0], 1'b0};
            rem_reg <= fits ? rem_shift - {1'b0, sum} : rem_shift;
            quo_reg <= {quo_reg[23:0], fits};
        end
    end

endmodule

@@ src/smx_back.sv @@
// Back end: exp-and-sum pass, reciprocal, then normalize-and-emit pass.
`timescale 1ns / 1ps
module smx_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      desc_valid,
    input  smx_pkg::vec_desc_t        desc,
    output logic                      desc_pop,
    input  logic                      sc_wr_en,
    input  logic [smx_pkg::AddrW-1:0] sc_wr_addr,
    input  logic [15:0]               sc_wr_data,
    output logic                      out_valid,
    output logic [15:0]               prob,
    output logic                      last_out,
    output logic                      active
);

    smx_pkg::back_state_t state_reg, state_next;

    logic [15:0] score_mem [smx_pkg::MaxLen];
    logic [16:0] exp_mem [smx_pkg::MaxLen];
    logic [15:0] sc_rd_reg;
    logic [16:0] ex_rd_reg;

    logic [smx_pkg::CntW-1:0]  idx_reg;
    logic [smx_pkg::CntW-1:0]  cnt_reg;
    logic [15:0]               max_reg;
    logic [22:0]               sum_reg;
    logic [24:0]               inv_reg;
    logic [41:0]               prod_reg;
    logic [32:0]               y_reg;
    logic                      valid_reg;
    logic                      lastf_reg;
    // Marks that the divider was started, so go is raised only on entering the reciprocal state.
    logic                      recip_started_reg;

    logic [smx_pkg::AddrW-1:0] rd_addr;
    logic                      rd_en;
    logic                      ex_wr;
    logic [16:0]               e_val;
    logic                      div_go;
    logic                      div_done;
    logic [24:0]               div_inv;
    logic                      idx_last;

    // Exp datapath.
    logic [15:0] n_val;
    logic [32:0] y_val;
    logic [3:0]  t_idx;
    logic [19:0] r_val;
    logic [16:0] t_hi;
    logic [16:0] t_lo;
    logic [36:0] d_mul;
    logic [16:0] v_val;
    logic [8:0]  k_val;
    logic [23:0] p_round;

    assign rd_addr = idx_reg[smx_pkg::AddrW-1:0];
    assign idx_last = idx_reg + 1'b1 == cnt_reg;

    assign n_val = 16'($signed(max_reg) - $signed(sc_rd_reg));
    assign y_val = n_val * smx_pkg::Log2eQ16;
    assign k_val = y_reg[32:24];
    assign t_idx = y_reg[23:20];
    assign r_val = y_reg[19:0];
    assign t_hi = smx_pkg::exp_tab({1'b0, t_idx});
    assign t_lo = smx_pkg::exp_tab(5'({1'b0, t_idx} + 5'd1));
    assign d_mul = (t_hi - t_lo) * r_val + 37'h80000;
    assign v_val = t_hi - 17'(d_mul >> 20);
    assign e_val = (k_val >= 9'd17) ? 17'd0 : v_val >> k_val;

    assign p_round = prod_reg[41:24] + {17'd0, prod_reg[23]} > 24'd65535
        ? 24'd65535 : 24'(prod_reg[41:24]) + {23'd0, prod_reg[23]};

    smx_recip u_recip (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .sum   (sum_reg),
        .done  (div_done),
        .inv   (div_inv)
    );

    always_ff @(posedge clk)
    begin
        if (sc_wr_en)
            score_mem[sc_wr_addr] <= sc_wr_data;
        if (rd_en)
            sc_rd_reg <= score_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ex_wr)
            exp_mem[rd_addr] <= e_val;
        if (rd_en)
            ex_rd_reg <= exp_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        desc_pop = 1'b0;
        rd_en = 1'b0;
        ex_wr = 1'b0;
        div_go = 1'b0;
        unique case (state_reg)
            smx_pkg::ST_IDLE:
            begin
                if (desc_valid)
                begin
                    desc_pop = 1'b1;
                    state_next = smx_pkg::ST_EXP_RD;
                end
            end
            smx_pkg::ST_EXP_RD:
            begin
                rd_en = 1'b1;
                state_next = smx_pkg::ST_EXP_MUL;
            end
            smx_pkg::ST_EXP_MUL:
                state_next = smx_pkg::ST_EXP_CALC;
            smx_pkg::ST_EXP_CALC:
            begin
                ex_wr = 1'b1;
                if (idx_last)
                begin
                    state_next = smx_pkg::ST_RECIP;
                end
                else
                    state_next = smx_pkg::ST_EXP_RD;
            end
            smx_pkg::ST_RECIP:
            begin
                if (div_done)
                    state_next = smx_pkg::ST_EMIT_RD;
            end
            smx_pkg::ST_EMIT_RD:
            begin
                rd_en = 1'b1;
                state_next = smx_pkg::ST_EMIT_MUL;
            end
            smx_pkg::ST_EMIT_MUL:
                state_next = smx_pkg::ST_EMIT_OUT;
            smx_pkg::ST_EMIT_OUT:
            begin
                state_next = idx_last ? smx_pkg::ST_IDLE : smx_pkg::ST_EMIT_RD;
            end
            default:
                state_next = smx_pkg::ST_IDLE;
        endcase
        // The divider starts the cycle after the sum is complete.
        if (state_reg == smx_pkg::ST_RECIP && !recip_started_reg)
            div_go = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smx_pkg::ST_IDLE;
            valid_reg <= 1'b0;
            recip_started_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= state_reg == smx_pkg::ST_EMIT_MUL;
            recip_started_reg <= state_reg == smx_pkg::ST_RECIP;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            smx_pkg::ST_IDLE:
            begin
                idx_reg <= '0;
                cnt_reg <= desc.count;
                max_reg <= desc.max_score;
                sum_reg <= '0;
            end
            smx_pkg::ST_EXP_MUL:
                y_reg <= y_val;
            smx_pkg::ST_EXP_CALC:
            begin
                sum_reg <= sum_reg + 23'(e_val);
                idx_reg <= idx_last ? '0 : idx_reg + 1'b1;
            end
            smx_pkg::ST_RECIP:
            begin
                if (div_done)
                    inv_reg <= div_inv;
            end
            smx_pkg::ST_EMIT_MUL:
                prod_reg <= ex_rd_reg * inv_reg;
            smx_pkg::ST_EMIT_OUT:
                idx_reg <= idx_reg + 1'b1;
            default:
            begin
            end
        endcase
        if (state_reg == smx_pkg::ST_EMIT_MUL)
            lastf_reg <= idx_last;
    end

    assign out_valid = valid_reg;
    assign prob = p_round[15:0];
    assign last_out = lastf_reg;
    assign active = state_reg != smx_pkg::ST_IDLE;

endmodule

@@ src/softmax_normalizer.sv @@
// Top level of the max-subtracted softmax normalizer.
//
//  channel  | ports                 | handshake
//  ---------+-----------------------+------------------------------
//  input    | score, last           | start high and busy low
//  result   | prob, last_out        | done strobe, one cycle each
//
// Loading takes one item per cycle while busy is low. After the final item, a vector's
// descriptor is fetched, then come the exp-and-sum pass, the bit-serial reciprocal and
// the normalize-and-emit pass.
// Reset clears all control state; the stores need no clearing pass.
// busy is high from the cycle after a vector's final item until its last result has
// left; the receiver cannot stall, and each result leaves before the next entry is read.
`timescale 1ns / 1ps
module softmax_normalizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] score,
    input  logic        last,
    output logic        done,
    output logic [15:0] prob,
    output logic        last_out
);

    logic                      take;
    logic                      wr_en;
    logic [smx_pkg::AddrW-1:0] wr_addr;
    logic [15:0]               wr_data;
    logic                      dv;
    smx_pkg::vec_desc_t        dsc;
    logic                      q_ne;
    logic                      q_full;
    smx_pkg::vec_desc_t        q_head;
    logic                      pop;
    logic                      active;

    // The score memory is shared, so loading waits while a vector is processed.
    assign busy = active || q_ne || q_full;
    assign take = start && !busy;

    smx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .score      (score),
        .last       (last),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .desc_valid (dv),
        .desc       (dsc)
    );

    smx_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (dv),
        .push_data (dsc),
        .pop       (pop),
        .not_empty (q_ne),
        .full      (q_full),
        .head      (q_head)
    );

    smx_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (q_ne),
        .desc       (q_head),
        .desc_pop   (pop),
        .sc_wr_en   (wr_en),
        .sc_wr_addr (wr_addr),
        .sc_wr_data (wr_data),
        .out_valid  (done),
        .prob       (prob),
        .last_out   (last_out),
        .active     (active)
    );

endmodule

@@ src/softmax_normalizer_checker.sv @@
// Port-level checker for the softmax normalizer, bound to the top level.
`timescale 1ns / 1ps
module softmax_normalizer_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [15:0] prob,
    input logic        last_out
);

    a_quiet_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> !done) else $error("result right after an accepted item");

    a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("results closer than two cycles");

    a_busy_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy && !$isunknown({prob, last_out}))
        else $error("result while idle or with unknown bits");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !done) else $error("result right after reset");

endmodule

bind softmax_normalizer softmax_normalizer_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .prob     (prob),
    .last_out (last_out)
);
